/* rtl/awc_pkg.sv */
// Shared types, constants and field widths for the anagram window counter.
package awc_pkg;

    // Default sizes
    localparam int AWC_MAX_PATTERN = 64;
    localparam int AWC_ALPHABET    = 26;

    // Field widths fixed by the stream format
    localparam int KIND_W     = 2;
    localparam int LETTER_W   = 5;
    localparam int TOTAL_W    = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // Item kinds carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    // One accepted input item
    typedef struct packed {
        kind_t               kind;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } awc_item_t;

    // One result item
    typedef struct packed {
        logic               match;
        logic [TOTAL_W-1:0] total;
        logic               end_of_text;
    } awc_result_t;

endpackage

/* rtl/awc_in_stage.sv */
// Input register with stream handshake for the anagram window counter.
module awc_in_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [awc_pkg::IN_DATA_W-1:0] s_tdata,   // [4:0] letter, rest zero
    input  logic [awc_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
    input  logic                          s_tlast,
    input  logic                          advance,
    output awc_pkg::awc_item_t            item,
    output logic                          item_valid
);
    import awc_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    awc_item_t item_reg;
    logic      take;

    // Accept a transaction when the register is empty or is moving on
    assign s_tready = !vld_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind   <= kind_t'(s_tuser);
            item_reg.letter <= s_tdata[LETTER_W-1:0];
            item_reg.last   <= s_tlast;
        end
    end

    assign item       = item_reg;
    assign item_valid = vld_reg;

endmodule

/* rtl/awc_core.sv */
// Pattern and window histograms, delay line, mismatch count and match total.
module awc_core
#(
    parameter int MAX_PATTERN = awc_pkg::AWC_MAX_PATTERN,
    parameter int ALPHABET    = awc_pkg::AWC_ALPHABET
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  awc_pkg::awc_item_t   item,
    input  logic                 step,
    output logic                 has_result,
    output awc_pkg::awc_result_t result
);
    import awc_pkg::*;

    localparam int HW = $clog2(MAX_PATTERN + 1);
    localparam int AW = $clog2(ALPHABET);
    localparam int MW = $clog2(ALPHABET + 1);

    logic [HW-1:0]       phist_reg [ALPHABET];
    logic [HW-1:0]       phist_next [ALPHABET];
    logic [HW-1:0]       whist_reg [ALPHABET];
    logic [HW-1:0]       whist_next [ALPHABET];
    logic [LETTER_W-1:0] recent_reg [MAX_PATTERN];
    logic [LETTER_W-1:0] recent_next [MAX_PATTERN];
    logic [HW-1:0]       plen_reg, plen_next;
    logic [HW-1:0]       fill_reg, fill_next;
    logic [MW-1:0]       pnz_reg, pnz_next;
    logic [MW-1:0]       mism_reg, mism_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic                letter_ok;
    logic [AW-1:0]       a_idx;
    logic [AW-1:0]       b_idx;
    logic [LETTER_W-1:0] oldest;
    logic [HW-1:0]       wa, pa, wa_up;
    logic [HW-1:0]       wb, pb, wb_dn;
    logic [HW-1:0]       fill_inc;
    logic                full;
    logic                push;
    logic [MW-1:0]       mism_up, mism_dn;
    logic                match_now;
    logic [TOTAL_W-1:0]  total_upd;

    assign letter_ok = (int'(item.letter) < ALPHABET);
    assign a_idx     = AW'(item.letter);

    // Entering letter: its two histogram entries
    assign wa    = whist_reg[a_idx];
    assign pa    = phist_reg[a_idx];
    assign wa_up = wa + HW'(1);

    // Oldest letter; with a one-letter window it is the entering letter
    assign oldest = (fill_reg == '0) ? item.letter : recent_reg[0];
    assign b_idx  = AW'(oldest);
    assign wb     = (b_idx == a_idx) ? wa_up : whist_reg[b_idx];
    assign pb     = phist_reg[b_idx];
    assign wb_dn  = wb - HW'(1);

    assign push     = (item.kind == KIND_TEXT) && letter_ok && (plen_reg != '0);
    assign fill_inc = fill_reg + HW'(1);
    assign full     = (fill_inc >= plen_reg);

    // Track the mismatch count across the increment, then the decrement
    always_comb
    begin
        if (wa == pa)
        begin
            mism_up = mism_reg + MW'(1);
        end
        else if (wa_up == pa)
        begin
            mism_up = mism_reg - MW'(1);
        end
        else
        begin
            mism_up = mism_reg;
        end

        if (wb == pb)
        begin
            mism_dn = mism_up + MW'(1);
        end
        else if (wb_dn == pb)
        begin
            mism_dn = mism_up - MW'(1);
        end
        else
        begin
            mism_dn = mism_up;
        end
    end

    assign match_now = push && full && (mism_up == '0);
    assign total_upd = (match_now && (total_reg != '1)) ? total_reg + TOTAL_W'(1) : total_reg;

    // Work out the next state and the result for the item in the input register
    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            phist_next[i] = phist_reg[i];
            whist_next[i] = whist_reg[i];
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            recent_next[i] = recent_reg[i];
        end
        plen_next  = plen_reg;
        fill_next  = fill_reg;
        pnz_next   = pnz_reg;
        mism_next  = mism_reg;
        total_next = total_reg;
        has_result = 1'b0;

        case (item.kind)
            KIND_CLEAR:
            begin
                for (int i = 0; i < ALPHABET; i++)
                begin
                    phist_next[i] = '0;
                    whist_next[i] = '0;
                end
                plen_next  = '0;
                fill_next  = '0;
                pnz_next   = '0;
                mism_next  = '0;
                total_next = '0;
            end
            KIND_PATTERN:
            begin
                if (letter_ok)
                begin
                    // Grow the pattern unless it is full
                    if (plen_reg < HW'(MAX_PATTERN))
                    begin
                        phist_next[a_idx] = pa + HW'(1);
                        plen_next         = plen_reg + HW'(1);
                        if (pa == '0)
                        begin
                            pnz_next = pnz_reg + MW'(1);
                        end
                    end
                    // Drop the window measured against the old pattern
                    for (int i = 0; i < ALPHABET; i++)
                    begin
                        whist_next[i] = '0;
                    end
                    fill_next  = '0;
                    total_next = '0;
                    mism_next  = pnz_next;
                end
            end
            KIND_TEXT:
            begin
                if (letter_ok)
                begin
                    has_result = 1'b1;
                    if (push)
                    begin
                        // Add the entering letter, remove the oldest once full
                        for (int i = 0; i < ALPHABET; i++)
                        begin
                            if ((AW'(i) == a_idx) && !(full && (AW'(i) == b_idx)))
                            begin
                                whist_next[i] = whist_reg[i] + HW'(1);
                            end
                            else if (full && (AW'(i) == b_idx) && (AW'(i) != a_idx))
                            begin
                                whist_next[i] = whist_reg[i] - HW'(1);
                            end
                        end
                        if (full)
                        begin
                            // Shift the delay line down, landing the new letter at its tail
                            for (int i = 0; i < MAX_PATTERN - 1; i++)
                            begin
                                if (HW'(i + 1) == fill_reg)
                                begin
                                    recent_next[i] = item.letter;
                                end
                                else
                                begin
                                    recent_next[i] = recent_reg[i + 1];
                                end
                            end
                            mism_next = mism_dn;
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_PATTERN; i++)
                            begin
                                if (HW'(i) == fill_reg)
                                begin
                                    recent_next[i] = item.letter;
                                end
                            end
                            fill_next = fill_inc;
                            mism_next = mism_up;
                        end
                        total_next = total_upd;
                    end
                    // Close the text: empty the window and the total
                    if (item.last)
                    begin
                        for (int i = 0; i < ALPHABET; i++)
                        begin
                            whist_next[i] = '0;
                        end
                        fill_next  = '0;
                        total_next = '0;
                        mism_next  = pnz_reg;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    assign result.match       = match_now;
    assign result.total       = total_upd;
    assign result.end_of_text = item.last;

    // Hold counters and histograms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                phist_reg[i] <= '0;
                whist_reg[i] <= '0;
            end
            plen_reg  <= '0;
            fill_reg  <= '0;
            pnz_reg   <= '0;
            mism_reg  <= '0;
            total_reg <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                phist_reg[i] <= phist_next[i];
                whist_reg[i] <= whist_next[i];
            end
            plen_reg  <= plen_next;
            fill_reg  <= fill_next;
            pnz_reg   <= pnz_next;
            mism_reg  <= mism_next;
            total_reg <= total_next;
        end
    end

    // Advance the delay line; entries past the fill level are never read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                recent_reg[i] <= recent_next[i];
            end
        end
    end

endmodule

/* rtl/awc_out_stage.sv */
// Result register with stream handshake for the anagram window counter.
module awc_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  awc_pkg::awc_result_t           result,
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [awc_pkg::OUT_DATA_W-1:0] m_tdata,  // [0] match, [32:1] match_total
    output logic                           m_tlast   // end_of_text
);
    import awc_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    awc_result_t res_reg;

    // The slot is free when empty or when its transaction completes now
    assign free = !vld_reg || m_tready;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {(OUT_DATA_W - TOTAL_W - 1)'(0), res_reg.total, res_reg.match};
    assign m_tlast  = res_reg.end_of_text;

endmodule

/* rtl/anagram_window_counter.sv */
// Top level of the sliding-window anagram counter.
//
//  channel | dir | tdata                        | tuser     | tlast
//  s_*     | in  | [4:0] letter                 | [1:0] kind| last text letter
//  m_*     | out | [0] match, [32:1] match_total| -         | end_of_text
//
//  One item per cycle while no result is stalled; a result passes from the input
//  register through the single histogram and mismatch update pass into the
//  result register.
//  Reset clears the histograms, counters and both valid flags; the delay line
//  holds no reset value and is read only below the fill level.
//  A stalled result holds the pipe for text letters; items with no result
//  still pass through while the result waits.
module anagram_window_counter
#(
    parameter int MAX_PATTERN = awc_pkg::AWC_MAX_PATTERN,
    parameter int ALPHABET    = awc_pkg::AWC_ALPHABET
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [awc_pkg::IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, rest zero
    input  logic [awc_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [awc_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] match, [32:1] match_total
    output logic                           m_tlast
);
    import awc_pkg::*;

    awc_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        has_result;
    logic        out_free;
    awc_result_t result;

    // Move the item on unless its result has nowhere to go
    assign advance = item_valid && (!has_result || out_free);

    awc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    awc_core
    #(
        .MAX_PATTERN (MAX_PATTERN),
        .ALPHABET    (ALPHABET)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .step       (advance),
        .has_result (has_result),
        .result     (result)
    );

    awc_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/awc_checker.sv */
// Port-level checks for the anagram window counter, bound to the top level.
module awc_port_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [awc_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [awc_pkg::KIND_W-1:0]     s_tuser,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [awc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import awc_pkg::*;

    // A waiting result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A match always comes with a nonzero total
    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[TOTAL_W:1] != '0)
        else $error("match reported with zero total");

    // An open output never blocks the input
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // The input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no waiting result");

    // A waiting input transaction holds still
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser)
            && $stable(s_tlast))
        else $error("stalled input changed");

endmodule

bind anagram_window_counter awc_port_checker u_awc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* verif/awc_checker.sv */
`timescale 1ns / 1ps
// Scoreboard that predicts and checks every anagram window report of the counter.
module awc_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [awc_pkg::IN_DATA_W-1:0]  s_tdata,   // [4:0] letter, rest zero
    input  logic [awc_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [awc_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] match, [32:1] match_total
    input  logic                           m_tlast,
    output int                             errors,
    output int                             pending
);
    import awc_pkg::*;

    // Own copy of the pattern and window state
    logic [6:0]          pat_count [AWC_ALPHABET];
    logic [6:0]          pat_len;
    logic [6:0]          win_count [AWC_ALPHABET];
    logic [LETTER_W-1:0] win_letters [$];
    int                  differing;
    logic [TOTAL_W-1:0]  anagram_total;
    awc_result_t         anagram_reports [$];

    // Empty the window and the total; every letter held by the pattern now differs
    function void restart_text();
        int a;
        win_letters.delete();
        anagram_total = '0;
        differing     = 0;
        for (a = 0; a < AWC_ALPHABET; a++)
        begin
            win_count[a] = '0;
            if (pat_count[a] != 0)
                differing++;
        end
    endfunction

    // Move one window count by one and keep the differing-letter count in step
    function void shift_window(input logic [LETTER_W-1:0] a, input bit up);
        bit was_off;
        bit now_off;
        was_off = win_count[a] != pat_count[a];
        if (up)
            win_count[a] = win_count[a] + 7'd1;
        else
            win_count[a] = win_count[a] - 7'd1;
        now_off = win_count[a] != pat_count[a];
        if (was_off && !now_off)
            differing--;
        else if (!was_off && now_off)
            differing++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_reports
        awc_result_t         got;
        awc_result_t         want;
        awc_result_t         report;
        kind_t               kind;
        logic [LETTER_W-1:0] letter;
        int                  a;
        if (!rst_n)
        begin
            for (a = 0; a < AWC_ALPHABET; a++)
                pat_count[a] = '0;
            pat_len = '0;
            restart_text();
            anagram_reports.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // Compare a result transaction with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.match       = m_tdata[0];
                got.total       = m_tdata[TOTAL_W:1];
                got.end_of_text = m_tlast;
                if (anagram_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: match %0b total %0d end %0b",
                             $time, got.match, got.total, got.end_of_text);
                end
                else
                begin
                    want = anagram_reports.pop_front();
                    if (got.match !== want.match)
                    begin
                        errors++;
                        $display("%0t: match expected %0b actual %0b",
                                 $time, want.match, got.match);
                    end
                    if (got.total !== want.total)
                    begin
                        errors++;
                        $display("%0t: match_total expected %0d actual %0d",
                                 $time, want.total, got.total);
                    end
                    if (got.end_of_text !== want.end_of_text)
                    begin
                        errors++;
                        $display("%0t: end_of_text expected %0b actual %0b",
                                 $time, want.end_of_text, got.end_of_text);
                    end
                end
            end

            // Advance the prediction for an input transaction
            if (s_tvalid && s_tready)
            begin
                kind   = kind_t'(s_tuser);
                letter = s_tdata[LETTER_W-1:0];
                if (kind == KIND_CLEAR)
                begin
                    for (a = 0; a < AWC_ALPHABET; a++)
                        pat_count[a] = '0;
                    pat_len = '0;
                    restart_text();
                end
                else if (kind != KIND_UNUSED && letter < AWC_ALPHABET)
                begin
                    if (kind == KIND_PATTERN)
                    begin
                        // Grow the pattern up to its limit, then drop the old window
                        if (pat_len < AWC_MAX_PATTERN)
                        begin
                            pat_count[letter] = pat_count[letter] + 7'd1;
                            pat_len           = pat_len + 7'd1;
                        end
                        restart_text();
                    end
                    else
                    begin
                        report.match = 1'b0;
                        if (pat_len != 0)
                        begin
                            win_letters = {win_letters, letter};
                            shift_window(letter, 1'b1);
                            // Full window: score it, then drop the oldest letter
                            if (win_letters.size() >= pat_len)
                            begin
                                if (differing == 0)
                                begin
                                    report.match = 1'b1;
                                    if (anagram_total != '1)
                                        anagram_total = anagram_total + 1;
                                end
                                shift_window(win_letters.pop_front(), 1'b0);
                            end
                        end
                        report.total       = anagram_total;
                        report.end_of_text = s_tlast;
                        anagram_reports    = {anagram_reports, report};
                        if (s_tlast)
                            restart_text();
                    end
                end
            end
            pending = anagram_reports.size();
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the anagram window counter testbench: clock, reset, stimulus and verdict.
module testbench;
    import awc_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 1300;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;     // [4:0] letter, rest zero
    logic [KIND_W-1:0]     s_tuser  = '0;     // [1:0] kind
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [0] match, [32:1] match_total
    logic                  m_tlast;

    int                  errors;
    int                  pending;
    int                  burst_left    = 0;
    int                  idle_cycles   = 0;
    int                  items_counted = 0;
    logic [LETTER_W-1:0] pattern_letters [$];

    anagram_window_counter u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    awc_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the result channel on a rotating mask that changes every phase
    always @(negedge clk)
    begin : result_stall
        static logic [15:0] ready_mask = 16'hffff;
        static int          phase_left = 0;
        static int          ready_bit  = 0;
        if (phase_left == 0)
        begin
            ready_mask = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
            phase_left = $urandom_range(32, 160);
        end
        phase_left--;
        ready_bit = (ready_bit + 1) % 16;
        m_tready <= ready_mask[ready_bit];
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one item in bursts with random gaps and hold it until accepted
    task automatic send_item(input kind_t kind, input logic [LETTER_W-1:0] letter,
                             input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-LETTER_W){1'b0}}, letter};
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (kind == KIND_CLEAR || (kind != KIND_UNUSED && letter < AWC_ALPHABET))
            items_counted++;
    endtask

    // Now and then slip in an item the block should ignore
    task automatic maybe_noise();
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_UNUSED, LETTER_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
            else
                send_item($urandom_range(0, 1) ? KIND_TEXT : KIND_PATTERN,
                          LETTER_W'($urandom_range(AWC_ALPHABET, 31)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        int                  choice;
        int                  plen;
        int                  span;
        int                  base;
        int                  tlen;
        int                  episode;
        int                  j;
        int                  k;
        int                  idx;
        logic [LETTER_W-1:0] pick;
        logic [LETTER_W-1:0] tmp;
        logic [LETTER_W-1:0] shuffled [$];

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pattern, ignored items, a two-letter pattern and a text
        send_item(KIND_TEXT,    5'd0,  1'b0);
        send_item(KIND_UNUSED,  5'd5,  1'b0);
        send_item(KIND_PATTERN, 5'd31, 1'b1);
        send_item(KIND_PATTERN, 5'd0,  1'b0);
        send_item(KIND_PATTERN, 5'd25, 1'b1);
        send_item(KIND_TEXT,    5'd25, 1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b0);
        send_item(KIND_TEXT,    5'd25, 1'b0);
        send_item(KIND_TEXT,    5'd31, 1'b1);
        send_item(KIND_TEXT,    5'd27, 1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b1);
        // Directed: a pattern letter mid-text restarts the window
        send_item(KIND_TEXT,    5'd25, 1'b0);
        send_item(KIND_PATTERN, 5'd0,  1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b0);
        send_item(KIND_TEXT,    5'd25, 1'b0);
        send_item(KIND_TEXT,    5'd0,  1'b1);
        // Directed: clear, then a text against the empty pattern
        send_item(KIND_CLEAR,   5'd16, 1'b1);
        send_item(KIND_TEXT,    5'd16, 1'b1);
        send_item(KIND_UNUSED,  5'd31, 1'b1);

        // Random: a pattern over a narrow or the full alphabet, then texts built from its letters
        episode = 0;
        while (items_counted < ITEM_TARGET)
        begin
            episode++;
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(KIND_CLEAR, LETTER_W'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
                pattern_letters.delete();
            end
            choice = $urandom_range(0, 19);
            if (choice == 0)
                plen = 0;
            else if (choice < 15)
                plen = $urandom_range(1, 6);
            else if (choice < 19)
                plen = $urandom_range(7, AWC_MAX_PATTERN);
            else
                plen = $urandom_range(AWC_MAX_PATTERN + 1, AWC_MAX_PATTERN + 8);
            span = ($urandom_range(0, 4) == 0) ? AWC_ALPHABET : $urandom_range(1, 3);
            base = $urandom_range(0, AWC_ALPHABET - span);

            repeat (plen)
            begin
                maybe_noise();
                pick = LETTER_W'(base + $urandom_range(0, span - 1));
                if (pattern_letters.size() < AWC_MAX_PATTERN)
                    pattern_letters = {pattern_letters, pick};
                send_item(KIND_PATTERN, pick, 1'($urandom_range(0, 1)));
            end

            repeat ($urandom_range(1, 3))
            begin
                if (pattern_letters.size() > 8)
                    tlen = pattern_letters.size() + $urandom_range(0, pattern_letters.size());
                else
                    tlen = $urandom_range(1, 24);
                shuffled.delete();
                for (j = 0; j < tlen; j++)
                begin
                    maybe_noise();
                    // Refill with a fresh permutation of the pattern
                    if (shuffled.size() == 0 && pattern_letters.size() != 0)
                    begin
                        shuffled = pattern_letters;
                        for (k = shuffled.size() - 1; k > 0; k--)
                        begin
                            idx           = $urandom_range(0, k);
                            tmp           = shuffled[k];
                            shuffled[k]   = shuffled[idx];
                            shuffled[idx] = tmp;
                        end
                    end
                    if (shuffled.size() != 0 && $urandom_range(0, 3) != 0)
                        pick = shuffled.pop_front();
                    else
                        pick = LETTER_W'(base + $urandom_range(0, span - 1));
                    send_item(KIND_TEXT, pick, j == tlen - 1);
                end
            end

            // Hold the sender until every report has drained
            if (episode % 8 == 0)
            begin
                s_tvalid <= 1'b0;
                burst_left = 0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
        end

        // Drain the reports, then watch a little longer for strays
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
